FILE: sv/sshc_pkg.sv
package sshc_pkg;

	localparam int unsigned FREQ_W      = 16;
	localparam int unsigned POS_W       = 32;
	localparam int unsigned BACKOFF_W   = 24;
	localparam int unsigned PHASE_W     = 2;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 24;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_FWD_DIR       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_DIR      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_FREQ     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_TICKS = 2'd3;

	localparam logic                 FWD_DIR_RST       = 1'b1;
	localparam logic                 HOME_DIR_RST      = 1'b0;
	localparam logic [FREQ_W-1:0]    HOME_FREQ_RST     = 16'd1000;
	localparam logic [BACKOFF_W-1:0] BACKOFF_TICKS_RST = 24'd100000;

	typedef struct packed {
		logic              cmd_valid;
		logic [FREQ_W-1:0] cmd_target_freq;
		logic              cmd_target_dir;
		logic              start_homing;
		logic              limit_level;
		logic              limit_fall;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

FILE: sv/sshc_tick_if.sv
interface sshc_tick_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd_valid;
	logic [sshc_pkg::FREQ_W-1:0] cmd_target_freq;
	logic                      cmd_target_dir;
	logic                      start_homing;
	logic                      limit_level;

	modport source (
		output valid, cmd_valid, cmd_target_freq, cmd_target_dir, start_homing, limit_level,
		input  ready
	);
	modport sink (
		input  valid, cmd_valid, cmd_target_freq, cmd_target_dir, start_homing, limit_level,
		output ready
	);
endinterface

FILE: sv/sshc_result_if.sv
interface sshc_result_if;
	logic                         valid;
	logic                         ready;
	logic                         step_level;
	logic                         dir_level;
	logic signed [sshc_pkg::POS_W-1:0] position;
	logic [sshc_pkg::FREQ_W-1:0]  run_freq;
	logic [sshc_pkg::PHASE_W-1:0] homing_phase;

	modport source (
		output valid, step_level, dir_level, position, run_freq, homing_phase,
		input  ready
	);
	modport sink (
		input  valid, step_level, dir_level, position, run_freq, homing_phase,
		output ready
	);
endinterface

FILE: sv/sshc_cfg_if.sv
interface sshc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [sshc_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [sshc_pkg::CFG_DATA_W-1:0] data;

	modport source (
		output valid, reg_index, data,
		input  ready
	);
	modport sink (
		input  valid, reg_index, data,
		output ready
	);
endinterface

FILE: sv/sshc_front.sv
module sshc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	sshc_tick_if.sink               tick,
	output logic                    push,
	output sshc_pkg::item_t         push_item,
	input  sshc_pkg::queue_status_t qstat
);

	logic            valid_s1;
	sshc_pkg::item_t item_s1;
	logic            limit_prev_q;
	logic            accept;

	assign tick.ready = !valid_s1 || !qstat.full;
	assign accept     = tick.valid && tick.ready;
	assign push       = valid_s1 && !qstat.full;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			limit_prev_q <= 1'b1;
		end else if (accept) begin
			valid_s1     <= 1'b1;
			limit_prev_q <= tick.limit_level;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// classify: flag a falling limit edge against the previous beat
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd_valid       <= tick.cmd_valid;
			item_s1.cmd_target_freq <= tick.cmd_target_freq;
			item_s1.cmd_target_dir  <= tick.cmd_target_dir;
			item_s1.start_homing    <= tick.start_homing;
			item_s1.limit_level     <= tick.limit_level;
			item_s1.limit_fall      <= limit_prev_q && !tick.limit_level;
		end
	end

endmodule

FILE: sv/sshc_queue.sv
module sshc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  sshc_pkg::item_t         push_item,
	input  logic                    pop,
	output sshc_pkg::item_t         head,
	output sshc_pkg::queue_status_t qstat
);

	sshc_pkg::item_t                    mem [sshc_pkg::QUEUE_DEPTH];
	logic [sshc_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [sshc_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [sshc_pkg::QCNT_W-1:0]        count_q;

	assign qstat.full  = count_q == sshc_pkg::QCNT_W'(sshc_pkg::QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign head        = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_item;
	end

endmodule

FILE: sv/sshc_back.sv
module sshc_back #(
	parameter int unsigned TICK_HZ = 1000000
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sshc_pkg::item_t         head,
	input  sshc_pkg::queue_status_t qstat,
	output logic                    pop,
	sshc_cfg_if.sink                cfg,
	sshc_result_if.source           result
);

	localparam int unsigned ACC_W = $clog2(TICK_HZ + (2 << sshc_pkg::FREQ_W));
	localparam logic [ACC_W-1:0] TICK = ACC_W'(TICK_HZ);

	typedef enum logic [sshc_pkg::PHASE_W-1:0] {
		HOME_IDLE,
		HOME_SEEK,
		HOME_LEAVE,
		HOME_RETREAT
	} home_state_t;

	logic                                fwd_dir_q;
	logic                                home_dir_q;
	logic [sshc_pkg::FREQ_W-1:0]         home_freq_q;
	logic [sshc_pkg::BACKOFF_W-1:0]      backoff_ticks_q;

	home_state_t                         hs_q, hs_d;
	logic [sshc_pkg::FREQ_W-1:0]         target_freq_q, target_freq_d;
	logic                                target_dir_q, target_dir_d;
	logic [sshc_pkg::FREQ_W-1:0]         run_freq_q, run_freq_d;
	logic                                dir_q, dir_d;
	logic                                step_q, step_d;
	logic [ACC_W-1:0]                    acc_q, acc_d;
	logic [sshc_pkg::POS_W-1:0]          pos_q, pos_d;
	logic [sshc_pkg::BACKOFF_W-1:0]      backoff_q, backoff_d;
	logic                                out_valid_q;

	logic [ACC_W-1:0]                    acc_sum;
	logic [ACC_W-1:0]                    acc_sub;

	assign cfg.ready = 1'b1;
	assign pop       = !qstat.empty && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_dir_q       <= sshc_pkg::FWD_DIR_RST;
			home_dir_q      <= sshc_pkg::HOME_DIR_RST;
			home_freq_q     <= sshc_pkg::HOME_FREQ_RST;
			backoff_ticks_q <= sshc_pkg::BACKOFF_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				sshc_pkg::REG_FWD_DIR:       fwd_dir_q       <= cfg.data[0];
				sshc_pkg::REG_HOME_DIR:      home_dir_q      <= cfg.data[0];
				sshc_pkg::REG_HOME_FREQ:     home_freq_q     <= cfg.data[sshc_pkg::FREQ_W-1:0];
				sshc_pkg::REG_BACKOFF_TICKS: backoff_ticks_q <= cfg.data[sshc_pkg::BACKOFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		acc_sum       = acc_q + (ACC_W'(run_freq_q) << 1);
		acc_sub       = acc_sum - TICK;
		acc_d         = acc_q;
		step_d        = step_q;
		pos_d         = pos_q;
		hs_d          = hs_q;
		target_freq_d = target_freq_q;
		target_dir_d  = target_dir_q;
		run_freq_d    = run_freq_q;
		dir_d         = dir_q;
		backoff_d     = backoff_q;

		// step generator runs on the state held before this beat
		if (run_freq_q != '0) begin
			if (acc_sum >= TICK) begin
				acc_d  = (acc_sub >= TICK) ? TICK - 1'b1 : acc_sub;
				step_d = !step_q;
				if (!step_q)
					pos_d = (dir_q == fwd_dir_q) ? pos_q + 1'b1 : pos_q - 1'b1;
			end else begin
				acc_d = acc_sum;
			end
		end

		if (head.cmd_valid) begin
			target_freq_d = head.cmd_target_freq;
			target_dir_d  = head.cmd_target_dir;
		end

		if (hs_q == HOME_IDLE && head.limit_fall) begin
			run_freq_d    = '0;
			target_freq_d = '0;
		end

		unique case (hs_q)
			HOME_IDLE: begin
				if (head.start_homing) begin
					hs_d       = HOME_SEEK;
					dir_d      = home_dir_q;
					run_freq_d = home_freq_q;
				end else begin
					dir_d      = target_dir_d;
					run_freq_d = target_freq_d;
				end
			end
			HOME_SEEK: begin
				if (!head.limit_level) begin
					dir_d = !dir_q;
					hs_d  = HOME_LEAVE;
				end
			end
			HOME_LEAVE: begin
				if (head.limit_level) begin
					hs_d      = HOME_RETREAT;
					backoff_d = '0;
				end
			end
			HOME_RETREAT: begin
				if (backoff_q >= backoff_ticks_q) begin
					run_freq_d    = '0;
					target_freq_d = '0;
					pos_d         = '0;
					hs_d          = HOME_IDLE;
				end else begin
					backoff_d = backoff_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q          <= HOME_IDLE;
			target_freq_q <= '0;
			target_dir_q  <= 1'b0;
			run_freq_q    <= '0;
			dir_q         <= 1'b0;
			step_q        <= 1'b0;
			acc_q         <= '0;
			pos_q         <= '0;
			backoff_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				hs_q          <= hs_d;
				target_freq_q <= target_freq_d;
				target_dir_q  <= target_dir_d;
				run_freq_q    <= run_freq_d;
				dir_q         <= dir_d;
				step_q        <= step_d;
				acc_q         <= acc_d;
				pos_q         <= pos_d;
				backoff_q     <= backoff_d;
				out_valid_q   <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.step_level   = step_q;
	assign result.dir_level    = dir_q;
	assign result.position     = pos_q;
	assign result.run_freq     = run_freq_q;
	assign result.homing_phase = hs_q;

	a_acc_below_tick: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q < TICK)
		else $error("phase accumulator reached tick rate");

	a_state_holds_without_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> ($stable(hs_q) && $stable(pos_q) && $stable(step_q)))
		else $error("axis state moved without a beat");

	a_homing_end_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && hs_q == HOME_RETREAT && hs_d == HOME_IDLE)
		|=> (pos_q == '0 && run_freq_q == '0 && target_freq_q == '0))
		else $error("homing end did not zero position and stop");

	a_stopped_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && run_freq_q == '0 && hs_q != HOME_RETREAT)
		|=> ($stable(step_q) && $stable(pos_q) && $stable(acc_q)))
		else $error("step edge while stopped");

endmodule

FILE: sv/stepper_step_dir_homing_controller.sv
// A tick beat passes the front register, a queue entry and the back state register, in
// that order, before its result shows. Throughput: one tick per cycle while result.ready
// holds; the front register, two-entry queue and back state register each pass one beat
// per cycle, so the back's state update (phase accumulator add and compare) sets the rate.
// Reset (arst_n low, asynchronous): axis state, homing phase and queue clear,
// configuration returns to its defaults; the block takes ticks from the first cycle.
module stepper_step_dir_homing_controller #(
	parameter int unsigned TICK_HZ = 1000000
) (
	input  logic          clk,
	input  logic          arst_n,
	sshc_tick_if.sink     tick,
	sshc_cfg_if.sink      cfg,
	sshc_result_if.source result
);

	logic                    push;
	logic                    pop;
	sshc_pkg::item_t         push_item;
	sshc_pkg::item_t         head;
	sshc_pkg::queue_status_t qstat;

	sshc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.push      (push),
		.push_item (push_item),
		.qstat     (qstat)
	);

	sshc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	sshc_back #(
		.TICK_HZ (TICK_HZ)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.cfg    (cfg),
		.result (result)
	);

endmodule
